// ----- hw/rtl/idxhp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idxhp_pkg
// Shared types, constants and helpers for the IDX header parser.
// ----------------------------------------------------------------------------
package idxhp_pkg;

    localparam int COUNT_BITS_DEF = 48;
    localparam int POS_BITS       = 48;
    localparam int OUT_COUNT_BITS = 48;
    localparam int HDR_BITS       = 11;

    localparam logic [POS_BITS-1:0] POS_MAX        = {POS_BITS{1'b1}};
    localparam logic [POS_BITS-1:0] POS_TYPE       = POS_BITS'(2);
    localparam logic [POS_BITS-1:0] POS_DIMS       = POS_BITS'(3);
    localparam logic [POS_BITS-1:0] POS_LEN_START  = POS_BITS'(4);
    localparam logic [POS_BITS-1:0] MIN_FILE_LAST  = POS_BITS'(7);
    localparam logic [HDR_BITS-1:0] HDR_FIXED      = HDR_BITS'(4);

    // element type codes
    localparam logic [7:0] TYPE_U8  = 8'h08;
    localparam logic [7:0] TYPE_S8  = 8'h09;
    localparam logic [7:0] TYPE_I16 = 8'h0B;
    localparam logic [7:0] TYPE_I32 = 8'h0C;
    localparam logic [7:0] TYPE_F32 = 8'h0D;
    localparam logic [7:0] TYPE_F64 = 8'h0E;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SHORT   = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        logic       known;
        logic [1:0] size_log2;
    } elem_info_t;

    // control for the dimension-length multiply-accumulate
    typedef struct packed {
        logic step;    // a length byte is consumed this cycle
        logic first;   // first byte of a length
        logic finish;  // last byte of a length
        logic clear;   // end of file, back to reset values
    } mac_ctl_t;

    function automatic elem_info_t elem_info(input logic [7:0] code);
        elem_info_t info;
        info = '{known: 1'b1, size_log2: 2'd0};
        case (code)
            TYPE_U8, TYPE_S8:   info.size_log2 = 2'd0;
            TYPE_I16:           info.size_log2 = 2'd1;
            TYPE_I32, TYPE_F32: info.size_log2 = 2'd2;
            TYPE_F64:           info.size_log2 = 2'd3;
            default:            info.known     = 1'b0;
        endcase
        return info;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/idxhp_count_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idxhp_count_mac
// Byte-serial multiply of the element count by each 32-bit dimension length.
// ----------------------------------------------------------------------------
module idxhp_count_mac #(
    parameter int COUNT_BITS = idxhp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire idxhp_pkg::mac_ctl_t   ctl,
    input  wire logic [7:0]            data,
    output logic [COUNT_BITS-1:0]      count_next,
    output logic                       ovf_next
);
    import idxhp_pkg::*;

    localparam int ACC_BITS = COUNT_BITS + 32;

    logic [COUNT_BITS-1:0] count_reg;
    logic                  ovf_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [ACC_BITS-1:0]   acc_next;
    logic [ACC_BITS-1:0]   acc_base;
    logic [COUNT_BITS+7:0] partial;
    logic                  wide_ovf;

    // count * len = sum over length bytes, most significant first
    assign partial  = {8'h00, count_reg} * {{COUNT_BITS{1'b0}}, data};
    assign acc_base = ctl.first ? '0 : {acc_reg[ACC_BITS-9:0], 8'h00};
    assign acc_next = acc_base + ACC_BITS'(partial);
    assign wide_ovf = |acc_next[ACC_BITS-1:COUNT_BITS];

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (ctl.step && ctl.finish)
        begin
            if (wide_ovf)
            begin
                count_next = '1;
                ovf_next   = 1'b1;
            end
            else
            begin
                count_next = acc_next[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_BITS'(1);
            ovf_reg   <= 1'b0;
        end
        else if (ctl.clear)
        begin
            count_reg <= COUNT_BITS'(1);
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/idxhp_status_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idxhp_status_eval
// Final file status from byte total, header fields and element count.
// ----------------------------------------------------------------------------
module idxhp_status_eval #(
    parameter int COUNT_BITS = idxhp_pkg::COUNT_BITS_DEF
) (
    input  wire logic [idxhp_pkg::POS_BITS-1:0] pos,
    input  wire logic [idxhp_pkg::HDR_BITS-1:0] hdr_len,
    input  wire idxhp_pkg::elem_info_t          info,
    input  wire logic                           hdr_err,
    input  wire logic                           ovf,
    input  wire logic [COUNT_BITS-1:0]          count,
    output idxhp_pkg::status_t                  status
);
    import idxhp_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS + 3 > POS_BITS) ? COUNT_BITS + 3 : POS_BITS;

    logic [POS_BITS-1:0] total;
    logic [POS_BITS-1:0] hdr_ext;
    logic [POS_BITS-1:0] body;
    logic [CMP_BITS-1:0] scaled;
    logic                too_short;
    logic                size_match;

    // last byte at position pos gives pos+1 bytes; pos never passes POS_MAX
    assign total      = pos + POS_BITS'(1);
    assign hdr_ext    = POS_BITS'(hdr_len);
    assign too_short  = total < hdr_ext;
    assign body       = total - hdr_ext;
    assign scaled     = CMP_BITS'(count) << info.size_log2;
    assign size_match = (CMP_BITS'(body) == scaled);

    always_comb
    begin
        if (pos < MIN_FILE_LAST)
        begin
            status = STATUS_SHORT;
        end
        else if (pos == POS_MAX || hdr_err || ovf || too_short || !info.known)
        begin
            status = STATUS_INVALID;
        end
        else if (size_match)
        begin
            status = STATUS_OK;
        end
        else
        begin
            status = STATUS_INVALID;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/idx_header_parser_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idx_header_parser_top
// Streaming IDX file checker: header parse, element count, payload pass-out.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  src      src_valid/src_ready    in_byte, last_byte
//  res      res_valid/res_ready    payload_valid, payload_byte, done_res, status,
//                                  type_code, dimension_count, element_count
//
//  One result per input byte; a byte is accepted every cycle while src_ready
//  is high, and its result passes through the input register, then the result
//  register, before it can transfer on res.
//  The dimension-length multiply runs one byte per cycle while the stream
//  advances, in a COUNT_BITS x 8 multiply-accumulate, so lengths never slow it.
//  Reset returns all parse state to the start of a file; so does the last byte.
//  A stall on res holds both stages; src_ready drops only when both are full.
// ----------------------------------------------------------------------------
module idx_header_parser_top #(
    parameter int COUNT_BITS = idxhp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 src_valid,
    output logic                                      src_ready,
    input  wire logic [7:0]                           in_byte,
    input  wire logic                                 last_byte,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output logic                                      payload_valid,
    output logic [7:0]                                payload_byte,
    output logic                                      done_res,
    output logic [1:0]                                status,
    output logic [7:0]                                type_code,
    output logic [7:0]                                dimension_count,
    output logic [idxhp_pkg::OUT_COUNT_BITS-1:0]      element_count
);
    import idxhp_pkg::*;

    localparam int EXT_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // parse state
    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pos_next;
    logic [7:0]          type_reg;
    logic [7:0]          type_next;
    logic [7:0]          dims_reg;
    logic [7:0]          dims_next;
    logic                hdr_err_reg;
    logic                hdr_err_next;

    // result stage
    logic                      res_valid_reg;
    logic                      pv_reg;
    logic [7:0]                pbyte_reg;
    logic                      done_reg;
    status_t                   status_reg;
    logic [7:0]                type_out_reg;
    logic [7:0]                dims_out_reg;
    logic [OUT_COUNT_BITS-1:0] count_out_reg;

    logic                  adv;
    logic                  res_free;
    logic [HDR_BITS-1:0]   hdr_len;
    logic [POS_BITS-1:0]   hdr_pos;
    logic                  in_len_area;
    logic                  pv_next;
    elem_info_t            info;
    elem_info_t            byte_info;
    mac_ctl_t              mac_ctl;
    logic [COUNT_BITS-1:0] count_next;
    logic                  ovf_next;
    status_t               status_next;
    logic [EXT_BITS-1:0]   count_ext;

    assign res_free  = !res_valid_reg || res_ready;
    assign adv       = s1_valid_reg && res_free;
    assign src_ready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            s1_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= last_byte;
        end
    end

    // header length 4 + 4 * dims
    assign hdr_len     = HDR_FIXED + {1'b0, dims_reg, 2'b00};
    assign hdr_pos     = POS_BITS'(hdr_len);
    assign in_len_area = (pos_reg >= POS_LEN_START) && (pos_reg < hdr_pos);
    assign pv_next     = (pos_reg >= POS_LEN_START) && !(pos_reg < hdr_pos);
    assign info        = elem_info(type_reg);
    assign byte_info   = elem_info(s1_byte_reg);

    always_comb
    begin
        type_next    = type_reg;
        dims_next    = dims_reg;
        hdr_err_next = hdr_err_reg;
        if (pos_reg < POS_TYPE)
        begin
            if (s1_byte_reg != 8'h00)
            begin
                hdr_err_next = 1'b1;
            end
        end
        else if (pos_reg == POS_TYPE)
        begin
            type_next = s1_byte_reg;
            if (!byte_info.known)
            begin
                hdr_err_next = 1'b1;
            end
        end
        else if (pos_reg == POS_DIMS)
        begin
            dims_next = s1_byte_reg;
            if (s1_byte_reg == 8'h00)
            begin
                hdr_err_next = 1'b1;
            end
        end

        if (s1_last_reg)
        begin
            pos_next = '0;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + POS_BITS'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // length bytes start at a multiple of four, so the byte phase is pos[1:0]
    assign mac_ctl = '{
        step:   adv && in_len_area,
        first:  pos_reg[1:0] == 2'd0,
        finish: pos_reg[1:0] == 2'd3,
        clear:  adv && s1_last_reg
    };

    idxhp_count_mac #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mac_ctl),
        .data       (s1_byte_reg),
        .count_next (count_next),
        .ovf_next   (ovf_next)
    );

    idxhp_status_eval #(
        .COUNT_BITS (COUNT_BITS)
    ) u_status_eval (
        .pos     (pos_reg),
        .hdr_len (hdr_len),
        .info    (info),
        .hdr_err (hdr_err_reg),
        .ovf     (ovf_next),
        .count   (count_next),
        .status  (status_next)
    );

    assign count_ext = EXT_BITS'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            type_reg      <= '0;
            dims_reg      <= '0;
            hdr_err_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                pos_reg <= pos_next;
                if (s1_last_reg)
                begin
                    type_reg    <= '0;
                    dims_reg    <= '0;
                    hdr_err_reg <= 1'b0;
                end
                else
                begin
                    type_reg    <= type_next;
                    dims_reg    <= dims_next;
                    hdr_err_reg <= hdr_err_next;
                end
            end
            if (res_free)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pv_reg    <= pv_next;
            pbyte_reg <= pv_next ? s1_byte_reg : 8'h00;
            done_reg  <= s1_last_reg;
            if (s1_last_reg)
            begin
                status_reg    <= status_next;
                type_out_reg  <= type_next;
                dims_out_reg  <= dims_next;
                count_out_reg <= count_ext[OUT_COUNT_BITS-1:0];
            end
            else
            begin
                status_reg    <= STATUS_OK;
                type_out_reg  <= '0;
                dims_out_reg  <= '0;
                count_out_reg <= '0;
            end
        end
    end

    assign res_valid       = res_valid_reg;
    assign payload_valid   = pv_reg;
    assign payload_byte    = pbyte_reg;
    assign done_res        = done_reg;
    assign status          = status_reg;
    assign type_code       = type_out_reg;
    assign dimension_count = dims_out_reg;
    assign element_count   = count_out_reg;

    // a file ends: the next byte starts over at position zero
    a_restart_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_last_reg |=> pos_reg == '0)
        else $error("position not cleared after last byte");

    // status fields stay zero except on the last-byte result
    a_status_only_on_done : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !done_reg |-> status_reg == STATUS_OK && count_out_reg == '0)
        else $error("status fields set on a non-final result");

    // payload bytes only come after the four fixed header bytes
    a_payload_after_header : assert property (@(posedge clk) disable iff (!rst_n)
        adv && pv_next |-> pos_reg >= POS_LEN_START && dims_reg != 8'h00 || hdr_err_reg)
        else $error("payload flagged inside the header");

endmodule
`default_nettype wire
